@@ sv/vector_dot_and_matrix_transform_defines.svh @@
// assertion macros shared by the vector unit modules
`ifndef VECTOR_DOT_AND_MATRIX_TRANSFORM_DEFINES_SVH
`define VECTOR_DOT_AND_MATRIX_TRANSFORM_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst is high
`define VDMT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, off while rst is high
`define VDMT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ sv/vdmt_pkg.sv @@
// shared types and codes of the vector unit
package vdmt_pkg;

  // exponent width of the internal double-style numbers
  localparam int unsigned EXP_W = 12;
  // normalized mantissa register width, leading one at the top bit
  localparam int unsigned NM_W = 56;

  // item operation codes
  typedef enum logic [2:0] {
    FUNC_WR_FRONT = 3'd0,
    FUNC_WR_BACK  = 3'd1,
    FUNC_RD_FRONT = 3'd2,
    FUNC_DOT      = 3'd3,
    FUNC_XFORM    = 3'd4,
    FUNC_SWAP     = 3'd5
  } func_t;

  // commands from the controller to the datapath
  typedef struct packed {
    logic       cap_wdata;
    logic       rd_back;
    logic [3:0] rd_addr;
    logic       cap_a;
    logic       cap_b;
    logic       mul;
    logic       norm;
    logic       align;
    logic       add;
    logic       round;
    logic       acc_clr;
    logic       narrow;
    logic       rbuf_wdata;
    logic       rbuf_read;
    logic [1:0] rbuf_idx;
    logic       wr_en;
    logic       wr_back;
    logic       wr_wdata;
    logic [3:0] wr_addr;
    logic       out_load;
    logic [3:0] out_dest;
    logic       out_last;
    logic       swap;
  } cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic norm_done;
    logic bypass;
    logic out_free;
  } sts_t;

endpackage

@@ sv/vdmt_ram.sv @@
// generic single-write, single-read ram with registered read data
module vdmt_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ sv/vdmt_datapath.sv @@
// register banks, multiply, double-precision accumulate and rounding to single
`include "vector_dot_and_matrix_transform_defines.svh"
module vdmt_datapath (
  input  logic             clk,
  input  logic             rst,
  input  vdmt_pkg::cmd_t   cmd,
  output vdmt_pkg::sts_t   sts,
  input  logic [31:0]      wdata_in,
  input  logic             cfg_wr_en,
  input  logic             cfg_wr_data,
  input  logic             out_ready,
  output logic             out_valid,
  output logic [39:0]      out_data,   // value [31:0], dest_index [35:32], zero fill
  output logic             out_last
);

  localparam int unsigned EW = vdmt_pkg::EXP_W;
  localparam int unsigned NW = vdmt_pkg::NM_W;
  localparam logic signed [EW-1:0] PROD_BIAS = 308;
  localparam logic signed [EW-1:0] ALIGN_MAX = 63;
  localparam logic signed [EW-1:0] NAR_BIAS  = 182;
  localparam logic signed [EW-1:0] FE_INF    = 255;
  localparam logic signed [EW-1:0] FE_MIN    = 1;
  localparam logic signed [EW-1:0] SH_NORM   = 29;
  localparam logic signed [EW-1:0] SH_BASE   = 30;
  localparam logic signed [EW-1:0] SH_MAX    = 54;
  localparam logic signed [EW-1:0] ONE       = 1;
  localparam logic signed [EW-1:0] STEP16    = 16;
  localparam logic signed [EW-1:0] STEP4     = 4;
  localparam logic [31:0] DEFAULT_NAN = 32'h7FBF_FFFF;
  localparam logic [30:0] INF_BITS    = 31'h7F80_0000;

  typedef struct packed {
    logic        s;
    logic        zero;
    logic        inf;
    logic        nan;
    logic [23:0] m;
    logic [7:0]  ef;
  } unpk_t;

  // split a single into class, mantissa and exponent after the flush
  function automatic unpk_t unpack(input logic [31:0] x, input logic fl);
    unpk_t u;
    u.s    = x[31];
    u.zero = 1'b0;
    u.inf  = 1'b0;
    u.nan  = 1'b0;
    u.m    = {1'b1, x[22:0]};
    u.ef   = x[30:23];
    if (x[30:23] == 8'hFF) begin
      u.nan = (x[22:0] != 23'd0);
      u.inf = (x[22:0] == 23'd0);
      u.m   = '0;
    end else if (x[30:23] == 8'h00) begin
      u.ef = 8'd1;
      u.m  = {1'b0, x[22:0]};
      if (x[22:0] == 23'd0 || fl) begin
        u.zero = 1'b1;
        u.m    = '0;
      end
    end
    return u;
  endfunction

  logic        flush;
  logic        sel;
  logic        rd_phys;
  logic [31:0] wdata_q;
  logic [31:0] opa;
  logic [31:0] opb;
  logic [31:0] rdata0;
  logic [31:0] rdata1;
  logic [31:0] dout;
  logic [31:0] rbuf [4];
  logic        wphys;
  logic [31:0] wr_data;

  logic [NW-1:0]        nreg;
  logic signed [EW-1:0] ne;
  logic                 p_s, p_zero, p_inf, p_nan;

  logic [NW-1:0]        acc_m;
  logic signed [EW-1:0] acc_e;
  logic                 acc_s, acc_zero, acc_inf, acc_nan;

  logic [NW-1:0]        xm_q, yal_q;
  logic signed [EW-1:0] xe_q;
  logic                 xs_q, sub_q;

  // bank select and flush mode
  always_ff @(posedge clk) begin
    if (rst) begin
      flush <= 1'b1;
      sel   <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        flush <= cfg_wr_data;
      end
      if (cmd.swap) begin
        sel <= ~sel;
      end
    end
  end

  // front bank lives in ram[sel], back bank in the other
  assign wphys   = sel ^ cmd.wr_back;
  assign wr_data = cmd.wr_wdata ? wdata_q : rbuf[cmd.rbuf_idx];

  vdmt_ram #(.WIDTH(32), .DEPTH(16)) u_bank0 (
    .clk   (clk),
    .we    (cmd.wr_en & ~wphys),
    .waddr (cmd.wr_addr),
    .wdata (wr_data),
    .raddr (cmd.rd_addr),
    .rdata (rdata0)
  );

  vdmt_ram #(.WIDTH(32), .DEPTH(16)) u_bank1 (
    .clk   (clk),
    .we    (cmd.wr_en & wphys),
    .waddr (cmd.wr_addr),
    .wdata (wr_data),
    .raddr (cmd.rd_addr),
    .rdata (rdata1)
  );

  assign dout = rd_phys ? rdata1 : rdata0;

  // operand and word captures
  always_ff @(posedge clk) begin
    rd_phys <= sel ^ cmd.rd_back;
    if (cmd.cap_wdata) wdata_q <= wdata_in;
    if (cmd.cap_a) opa <= dout;
    if (cmd.cap_b) opb <= dout;
  end

  // multiply terms
  unpk_t       ua, ub;
  logic [47:0] prod;
  logic        pn_nan, pn_inf, pn_zero;

  always_comb begin
    ua      = unpack(opa, flush);
    ub      = unpack(opb, flush);
    prod    = ua.m * ub.m;
    pn_nan  = ua.nan | ub.nan | (ua.inf & ub.zero) | (ua.zero & ub.inf);
    pn_inf  = (ua.inf | ub.inf) & ~pn_nan;
    pn_zero = (ua.zero | ub.zero) & ~pn_nan & ~pn_inf;
  end

  // normalize step: 16, 4 or 1 bit left per cycle
  logic norm_done;
  assign norm_done = nreg[NW-1] | (nreg == '0);

  // alignment of the smaller operand with sticky
  logic                 a_big;
  logic [NW-1:0]        xm_c, ym_c;
  logic signed [EW-1:0] xe_c, ye_c, dd;
  logic [5:0]           dc;
  logic                 lost;
  logic [NW-1:0]        yal_c;

  always_comb begin
    a_big = (acc_e > ne) || ((acc_e == ne) && (acc_m >= nreg));
    xm_c  = a_big ? acc_m : nreg;
    ym_c  = a_big ? nreg : acc_m;
    xe_c  = a_big ? acc_e : ne;
    ye_c  = a_big ? ne : acc_e;
    dd    = xe_c - ye_c;
    dc    = (dd > ALIGN_MAX) ? 6'd63 : dd[5:0];
    lost  = |(ym_c & ~({NW{1'b1}} << dc));
    yal_c = (ym_c >> dc) | {{(NW-1){1'b0}}, lost};
  end

  // special operands skip the adder
  logic bypass, nan_r;
  assign bypass = acc_nan | p_nan | acc_inf | p_inf | acc_zero | p_zero;
  assign nan_r  = acc_nan | p_nan | (acc_inf & p_inf & (acc_s != p_s));

  // add or subtract of aligned mantissas
  logic [NW:0]   sum_c;
  logic [NW-1:0] diff_c;
  assign sum_c  = {1'b0, xm_q} + {1'b0, yal_q};
  assign diff_c = xm_q - yal_q;

  // round to 53 bits, nearest even
  logic        rup;
  logic [53:0] rsum;
  assign rup  = nreg[2] & ((|nreg[1:0]) | nreg[3]);
  assign rsum = {1'b0, nreg[NW-1:3]} + {53'd0, rup};

  // number register, product flags and accumulator
  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      nreg   <= {prod, 8'd0};
      ne     <= $signed({{(EW-8){1'b0}}, ua.ef}) + $signed({{(EW-8){1'b0}}, ub.ef}) - PROD_BIAS;
      p_s    <= ua.s ^ ub.s;
      p_nan  <= pn_nan;
      p_inf  <= pn_inf;
      p_zero <= pn_zero;
    end else if (cmd.norm) begin
      if (nreg[NW-1 -: 16] == 16'd0) begin
        nreg <= nreg << 16;
        ne   <= ne - STEP16;
      end else if (nreg[NW-1 -: 4] == 4'd0) begin
        nreg <= nreg << 4;
        ne   <= ne - STEP4;
      end else begin
        nreg <= nreg << 1;
        ne   <= ne - ONE;
      end
    end else if (cmd.add) begin
      if (!sub_q) begin
        if (sum_c[NW]) begin
          nreg <= {sum_c[NW:2], sum_c[1] | sum_c[0]};
          ne   <= xe_q + ONE;
        end else begin
          nreg <= sum_c[NW-1:0];
          ne   <= xe_q;
        end
      end else begin
        nreg <= diff_c;
        ne   <= xe_q;
      end
    end

    if (cmd.align && !bypass) begin
      xm_q  <= xm_c;
      yal_q <= yal_c;
      xe_q  <= xe_c;
      xs_q  <= a_big ? acc_s : p_s;
      sub_q <= acc_s ^ p_s;
    end

    if (cmd.acc_clr) begin
      acc_s    <= 1'b0;
      acc_zero <= 1'b1;
      acc_inf  <= 1'b0;
      acc_nan  <= 1'b0;
    end else if (cmd.align && bypass) begin
      if (nan_r) begin
        acc_nan <= 1'b1;
      end else if (acc_inf) begin
        acc_inf <= 1'b1;
      end else if (p_inf) begin
        acc_inf  <= 1'b1;
        acc_s    <= p_s;
        acc_zero <= 1'b0;
      end else if (p_zero) begin
        if (acc_zero) acc_s <= acc_s & p_s;
      end else begin
        acc_m    <= nreg;
        acc_e    <= ne;
        acc_s    <= p_s;
        acc_zero <= 1'b0;
      end
    end else if (cmd.round) begin
      if (nreg == '0) begin
        acc_zero <= 1'b1;
        acc_s    <= 1'b0;
      end else begin
        acc_zero <= 1'b0;
        acc_s    <= xs_q;
        if (rsum[53]) begin
          acc_m <= {1'b1, {(NW-1){1'b0}}};
          acc_e <= ne + ONE;
        end else begin
          acc_m <= {rsum[52:0], 3'd0};
          acc_e <= ne;
        end
      end
    end
  end

  // narrowing of the accumulator to single
  logic signed [EW-1:0] fe, sh;
  logic [106:0]         nt;
  logic [52:0]          nq;
  logic                 nup;
  logic [31:0]          q32, nval, nres, nflush;

  always_comb begin
    fe   = acc_e + NAR_BIAS;
    sh   = (fe >= FE_MIN) ? SH_NORM : (SH_BASE - fe);
    nt   = {acc_m[NW-1:3], 54'd0} >> sh[5:0];
    nq   = nt[106:54];
    nup  = nt[53] & ((|nt[52:0]) | nq[0]);
    q32  = nq[31:0] + {31'd0, nup};
    nval = (fe >= FE_MIN) ? ({1'b0, fe[7:0] - 8'd1, 23'd0} + q32) : q32;
    nres = {acc_s, nval[30:0]};
    if (flush && nres[30:23] == 8'd0 && nres[22:0] != 23'd0) begin
      nres = {acc_s, 31'd0};
    end
    // a zero sum ignores the stale exponent
    if (acc_nan) begin
      nflush = DEFAULT_NAN;
    end else if (acc_inf) begin
      nflush = {acc_s, INF_BITS};
    end else if (acc_zero) begin
      nflush = {acc_s, 31'd0};
    end else if (fe >= FE_INF) begin
      nflush = {acc_s, INF_BITS};
    end else if (sh > SH_MAX) begin
      nflush = {acc_s, 31'd0};
    end else begin
      nflush = nres;
    end
  end

  // result buffer
  always_ff @(posedge clk) begin
    if (cmd.narrow) begin
      rbuf[cmd.rbuf_idx] <= nflush;
    end else if (cmd.rbuf_wdata) begin
      rbuf[cmd.rbuf_idx] <= wdata_q;
    end else if (cmd.rbuf_read) begin
      rbuf[cmd.rbuf_idx] <= dout;
    end
  end

  // output word register
  logic out_free;
  assign out_free = ~out_valid | out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (cmd.out_load) begin
      out_data <= {4'd0, cmd.out_dest, rbuf[cmd.rbuf_idx]};
      out_last <= cmd.out_last;
    end
  end

  assign sts.norm_done = norm_done;
  assign sts.bypass    = bypass;
  assign sts.out_free  = out_free;

  // checks
  `VDMT_ASSERT_IMP(a_align_norm, cmd.align, (nreg[NW-1] || nreg == '0), "align unnormalized")
  `VDMT_ASSERT_IMP(a_round_norm, cmd.round, (nreg[NW-1] || nreg == '0), "round unnormalized")
  `VDMT_ASSERT_IMP(a_out_free, cmd.out_load, (!out_valid || out_ready), "output word overwritten")

endmodule

@@ sv/vdmt_ctrl.sv @@
// sequencer of the vector unit: decodes items and steps the datapath
`include "vector_dot_and_matrix_transform_defines.svh"
module vdmt_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic [2:0]     in_func,
  input  logic [3:0]     in_index,
  input  logic [1:0]     in_n,
  input  logic [1:0]     in_m,
  output vdmt_pkg::cmd_t cmd,
  input  vdmt_pkg::sts_t sts
);

  typedef enum logic [14:0] {
    S_IDLE     = 15'h0001,
    S_DISPATCH = 15'h0002,
    S_RD_WAIT  = 15'h0004,
    S_RD_A     = 15'h0008,
    S_RD_B     = 15'h0010,
    S_CAP_B    = 15'h0020,
    S_MUL      = 15'h0040,
    S_PNORM    = 15'h0080,
    S_ALIGN    = 15'h0100,
    S_ADD      = 15'h0200,
    S_SNORM    = 15'h0400,
    S_ROUND    = 15'h0800,
    S_TERM_END = 15'h1000,
    S_NARROW   = 15'h2000,
    S_EMIT     = 15'h4000
  } state_t;

  state_t          st, st_next;
  vdmt_pkg::func_t func_q;
  logic [3:0]      ri_q;
  logic [1:0]      n_q, m_q;
  logic [1:0]      term, term_next;
  logic [1:0]      row, row_next;
  logic [1:0]      k, k_next;
  logic            emit_last;
  logic [3:0]      emit_dest;

  assign in_ready = (st == S_IDLE);

  // destination and last flag of the current output word
  always_comb begin
    emit_last = 1'b1;
    emit_dest = ri_q;
    case (func_q)
      vdmt_pkg::FUNC_DOT: begin
        emit_dest = {n_q, 2'b11};
      end
      vdmt_pkg::FUNC_XFORM: begin
        emit_dest = {n_q, k};
        emit_last = (k == 2'd3);
      end
      default: begin
        emit_dest = ri_q;
      end
    endcase
  end

  // next state and commands
  always_comb begin
    st_next   = st;
    term_next = term;
    row_next  = row;
    k_next    = k;
    cmd       = '0;
    case (st)
      S_IDLE: begin
        if (in_valid) begin
          cmd.cap_wdata = 1'b1;
          st_next       = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        k_next = 2'd0;
        case (func_q)
          vdmt_pkg::FUNC_WR_FRONT: begin
            cmd.rbuf_wdata = 1'b1;
            st_next        = S_EMIT;
          end
          vdmt_pkg::FUNC_WR_BACK: begin
            cmd.wr_en    = 1'b1;
            cmd.wr_back  = 1'b1;
            cmd.wr_wdata = 1'b1;
            cmd.wr_addr  = ri_q;
            st_next      = S_IDLE;
          end
          vdmt_pkg::FUNC_RD_FRONT: begin
            cmd.rd_addr = ri_q;
            st_next     = S_RD_WAIT;
          end
          vdmt_pkg::FUNC_DOT, vdmt_pkg::FUNC_XFORM: begin
            cmd.acc_clr = 1'b1;
            term_next   = 2'd0;
            row_next    = 2'd0;
            st_next     = S_RD_A;
          end
          vdmt_pkg::FUNC_SWAP: begin
            cmd.swap = 1'b1;
            st_next  = S_IDLE;
          end
          default: begin
            st_next = S_IDLE;
          end
        endcase
      end
      S_RD_WAIT: begin
        cmd.rbuf_read = 1'b1;
        st_next       = S_EMIT;
      end
      S_RD_A: begin
        if (func_q == vdmt_pkg::FUNC_XFORM) begin
          cmd.rd_back = 1'b1;
          cmd.rd_addr = {term, row};
        end else begin
          cmd.rd_addr = {m_q, term};
        end
        st_next = S_RD_B;
      end
      S_RD_B: begin
        cmd.cap_a   = 1'b1;
        cmd.rd_addr = {n_q, term};
        st_next     = S_CAP_B;
      end
      S_CAP_B: begin
        cmd.cap_b = 1'b1;
        st_next   = S_MUL;
      end
      S_MUL: begin
        cmd.mul = 1'b1;
        st_next = S_PNORM;
      end
      S_PNORM: begin
        if (sts.norm_done) begin
          st_next = S_ALIGN;
        end else begin
          cmd.norm = 1'b1;
        end
      end
      S_ALIGN: begin
        cmd.align = 1'b1;
        st_next   = sts.bypass ? S_TERM_END : S_ADD;
      end
      S_ADD: begin
        cmd.add = 1'b1;
        st_next = S_SNORM;
      end
      S_SNORM: begin
        if (sts.norm_done) begin
          st_next = S_ROUND;
        end else begin
          cmd.norm = 1'b1;
        end
      end
      S_ROUND: begin
        cmd.round = 1'b1;
        st_next   = S_TERM_END;
      end
      S_TERM_END: begin
        if (term == 2'd3) begin
          st_next = S_NARROW;
        end else begin
          term_next = term + 2'd1;
          st_next   = S_RD_A;
        end
      end
      S_NARROW: begin
        cmd.narrow   = 1'b1;
        cmd.rbuf_idx = row;
        if (func_q == vdmt_pkg::FUNC_XFORM && row != 2'd3) begin
          cmd.acc_clr = 1'b1;
          row_next    = row + 2'd1;
          term_next   = 2'd0;
          st_next     = S_RD_A;
        end else begin
          k_next  = 2'd0;
          st_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          cmd.rbuf_idx = k;
          cmd.out_dest = emit_dest;
          cmd.out_last = emit_last;
          cmd.wr_en    = (func_q != vdmt_pkg::FUNC_RD_FRONT);
          cmd.wr_addr  = emit_dest;
          if (emit_last) begin
            st_next = S_IDLE;
          end else begin
            k_next = k + 2'd1;
          end
        end
      end
      default: begin
        st_next = S_IDLE;
      end
    endcase
  end

  // state and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      st   <= S_IDLE;
      term <= 2'd0;
      row  <= 2'd0;
      k    <= 2'd0;
    end else begin
      st   <= st_next;
      term <= term_next;
      row  <= row_next;
      k    <= k_next;
    end
    if (st == S_IDLE && in_valid) begin
      func_q <= vdmt_pkg::func_t'(in_func);
      ri_q   <= in_index;
      n_q    <= in_n;
      m_q    <= in_m;
    end
  end

  // checks
  `VDMT_ASSERT_IMP(a_narrow_term, st == S_NARROW, term == 2'd3, "narrow before fourth term")
  `VDMT_ASSERT_NXT(a_last_idle, (st == S_EMIT && sts.out_free && emit_last), st == S_IDLE, "no return to idle after last word")
  `VDMT_ASSERT_NXT(a_accept_disp, (in_valid && in_ready), st == S_DISPATCH, "accepted word not dispatched")

endmodule

@@ sv/vector_dot_and_matrix_transform.sv @@
// Four-element single-precision vector unit with front and back register banks.
//
// Input channel s_axis: one word per item, operation code in tuser, operands in tdata.
// Write front register and read front register give one output word; write back
// register and swap banks give none; inner product gives one word for register 4n+3;
// transform gives four words for registers 4n..4n+3, tlast on the fourth.
// Output channel m_axis: value and destination register in tdata, tlast on the
// final word of an item.
// Items are taken one at a time. Each product term reads, captures and multiplies its
// operands, normalizes the product and aligns it; a special operand then skips the adder,
// else the term adds, normalizes the sum and rounds.
// Reset clears the controller, selects bank 0 as front and sets the flush mode;
// register contents stay undefined until written.
// When the receiver stalls the unit holds its word and waits before loading the next one;
// a new item may be taken while the last word of the previous one waits. cfg_wr_en with
// cfg_wr_data sets the denormal flush mode; the user must do so only while idle (not enforced).
module vector_dot_and_matrix_transform (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // reg_index [3:0], vec_n [5:4], vec_m [7:6], write_data [39:8]
  input  logic [2:0]  s_axis_tuser,   // func [2:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // value [31:0], dest_index [35:32], zero fill [39:36]
  output logic        m_axis_tlast,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data
);

  vdmt_pkg::cmd_t cmd;
  vdmt_pkg::sts_t sts;

  // controller
  vdmt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_func  (s_axis_tuser),
    .in_index (s_axis_tdata[3:0]),
    .in_n     (s_axis_tdata[5:4]),
    .in_m     (s_axis_tdata[7:6]),
    .cmd      (cmd),
    .sts      (sts)
  );

  // datapath
  vdmt_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .wdata_in    (s_axis_tdata[39:8]),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .out_ready   (m_axis_tready),
    .out_valid   (m_axis_tvalid),
    .out_data    (m_axis_tdata),
    .out_last    (m_axis_tlast)
  );

endmodule

@@ tb/vector_unit_checker.sv @@
// checker that predicts and compares the output words of the vector unit
module vector_unit_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,
  input  logic [2:0]  s_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [39:0] m_axis_tdata,
  input  logic        m_axis_tlast,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,
  output int          mismatches,
  output int          pending
);

  localparam logic [31:0] QUIET_NAN = 32'h7FBF_FFFF;

  typedef struct {
    logic [31:0] value;
    logic [3:0]  dest;
    logic        last;
  } word_t;

  logic [31:0] front_regs [16];
  logic [31:0] back_regs [16];
  logic        flush_mode;
  word_t       expected_words [$];

  // denormal to signed zero when flushing
  function automatic logic [31:0] flush_denorm(input logic [31:0] x);
    if (flush_mode && x[30:23] == 8'd0 && x[22:0] != 23'd0) return {x[31], 31'd0};
    return x;
  endfunction

  // exact single to double widening
  function automatic real single_to_real(input logic [31:0] raw);
    logic [31:0] f;
    logic [63:0] bits;
    logic [22:0] man;
    int          ex;
    f   = flush_denorm(raw);
    man = f[22:0];
    if (f[30:23] == 8'hFF) begin
      bits = (man != 0) ? 64'h7FF8_0000_0000_0000 : {f[31], 63'h7FF0_0000_0000_0000};
    end else if (f[30:23] == 8'd0) begin
      if (man == 0) begin
        bits = {f[31], 63'd0};
      end else begin
        ex = -127;
        while (man[22] == 1'b0) begin
          man = man << 1;
          ex--;
        end
        man = man << 1;
        bits = {f[31], 11'(ex + 1023), man, 29'd0};
      end
    end else begin
      bits = {f[31], 11'(f[30:23] + 896), man, 29'd0};
    end
    return $bitstoreal(bits);
  endfunction

  // double to single, nearest even, then flush
  function automatic logic [31:0] real_to_single(input real d);
    logic [63:0] b, sig, q, rem, half;
    logic [31:0] val;
    int          fe, shift;
    b = $realtobits(d);
    if (b[62:52] == 11'h7FF) begin
      if (b[51:0] != 0) return QUIET_NAN;
      return {b[63], 31'h7F80_0000};
    end
    if (b[62:52] == 11'd0) return {b[63], 31'd0};
    fe = int'(b[62:52]) - 896;
    if (fe >= 255) return {b[63], 31'h7F80_0000};
    sig   = {11'd1, b[51:0]};
    shift = (fe >= 1) ? 29 : 29 + (1 - fe);
    if (shift > 54) return {b[63], 31'd0};
    q    = sig >> shift;
    rem  = sig & ((64'd1 << shift) - 1);
    half = 64'd1 << (shift - 1);
    if (rem > half || (rem == half && q[0])) q++;
    if (fe >= 1) val = (32'(fe - 1) << 23) + q[31:0];
    else val = q[31:0];
    return flush_denorm({b[63], 31'd0} | val);
  endfunction

  // prediction of one accepted input word
  task automatic predict_item(input logic [2:0] op, input logic [39:0] d);
    logic [3:0]  ri;
    logic [1:0]  vn, vm;
    logic [31:0] wd;
    logic [31:0] row_res [4];
    logic [31:0] tmp [16];
    real         vin [4];
    real         acc;
    ri = d[3:0];
    vn = d[5:4];
    vm = d[7:6];
    wd = d[39:8];
    case (op)
      vdmt_pkg::FUNC_WR_FRONT: begin
        front_regs[ri] = wd;
        expected_words.push_back('{wd, ri, 1'b1});
      end
      vdmt_pkg::FUNC_WR_BACK: back_regs[ri] = wd;
      vdmt_pkg::FUNC_RD_FRONT: expected_words.push_back('{front_regs[ri], ri, 1'b1});
      vdmt_pkg::FUNC_DOT: begin
        acc = 0.0;
        for (int i = 0; i < 4; i++)
          acc = acc + single_to_real(front_regs[4 * vm + i]) *
                      single_to_real(front_regs[4 * vn + i]);
        front_regs[4 * vn + 3] = real_to_single(acc);
        expected_words.push_back('{front_regs[4 * vn + 3], 4'(4 * vn + 3), 1'b1});
      end
      vdmt_pkg::FUNC_XFORM: begin
        for (int i = 0; i < 4; i++) vin[i] = single_to_real(front_regs[4 * vn + i]);
        for (int i = 0; i < 4; i++) begin
          acc = 0.0;
          for (int j = 0; j < 4; j++)
            acc = acc + single_to_real(back_regs[i + 4 * j]) * vin[j];
          row_res[i] = real_to_single(acc);
        end
        for (int i = 0; i < 4; i++) begin
          front_regs[4 * vn + i] = row_res[i];
          expected_words.push_back('{row_res[i], 4'(4 * vn + i), i == 3});
        end
      end
      vdmt_pkg::FUNC_SWAP: begin
        tmp = front_regs;
        front_regs = back_regs;
        back_regs = tmp;
      end
      default: ;
    endcase
  endtask

  // compare output words, then predict input words
  always @(posedge clk) begin
    word_t exp_w;
    if (rst) begin
      flush_mode = 1'b1;
      expected_words.delete();
      mismatches = 0;
      for (int i = 0; i < 16; i++) begin
        front_regs[i] = '0;
        back_regs[i] = '0;
      end
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_words.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected word: value %h dest %0d last %b",
                     m_axis_tdata[31:0], m_axis_tdata[35:32], m_axis_tlast);
        end else begin
          exp_w = expected_words.pop_front();
          if (exp_w.value !== m_axis_tdata[31:0] || exp_w.dest !== m_axis_tdata[35:32] ||
              exp_w.last !== m_axis_tlast) begin
            mismatches++;
            if (mismatches <= 10)
              $display("word mismatch: expected value %h dest %0d last %b, got %h %0d %b",
                       exp_w.value, exp_w.dest, exp_w.last,
                       m_axis_tdata[31:0], m_axis_tdata[35:32], m_axis_tlast);
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) predict_item(s_axis_tuser, s_axis_tdata);
      if (cfg_wr_en) flush_mode = cfg_wr_data;
    end
    pending = expected_words.size();
  end

endmodule

@@ tb/vector_dot_and_matrix_transform_tb.sv @@
// stimulus and verdict for the vector unit testbench
module vector_dot_and_matrix_transform_tb;

  localparam logic [2:0] FUNC_SPARE_LO = 3'd6;
  localparam logic [2:0] FUNC_SPARE_HI = 3'd7;
  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int DRAIN_CYCLES = 500;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;   // reg_index [3:0], vec_n [5:4], vec_m [7:6], write_data [39:8]
  logic [2:0]  s_axis_tuser = '0;   // func [2:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;        // value [31:0], dest_index [35:32], zero fill [39:36]
  logic        m_axis_tlast;
  logic        cfg_wr_en = 1'b0;
  logic        cfg_wr_data = 1'b0;

  int mismatches;
  int pending;
  int send_idle_pct = 37;
  int recv_idle_pct = 53;
  int cycles = 0;
  logic hold_go = 1'b0;
  int hold_left = 0;
  logic hold_used = 1'b0;

  vector_dot_and_matrix_transform u_top (.*);

  vector_unit_checker u_checker (.*);

  // clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // receiver: random stalls plus one long hold-off
  always @(negedge clk) begin
    if (hold_go && !hold_used) begin
      hold_used = 1'b1;
      hold_left = 300;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // one word on the input channel, called at a falling edge
  task automatic send_item(input logic [2:0] op, input logic [39:0] d);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= d;
    do @(posedge clk); while (!s_axis_tready);
    @(negedge clk);
  endtask

  // float operand with a bias toward usable magnitudes
  function automatic logic [31:0] pick_float();
    int k;
    k = $urandom_range(99);
    if (k < 70) return {1'($urandom), 8'($urandom_range(154, 100)), 23'($urandom)};
    if (k < 80) return {1'($urandom), 8'd0, 23'($urandom_range(32'h7F_FFFF, 1))};
    if (k < 85) return {1'($urandom), 31'd0};
    if (k < 90) return {1'($urandom), 31'h7F80_0000};
    if (k < 95) return {1'($urandom), 8'hFF, 23'($urandom_range(32'h7F_FFFF, 1))};
    return $urandom;
  endfunction

  task automatic write_reg(input logic [2:0] op, input logic [3:0] idx, input logic [31:0] v);
    send_item(op, {v, 4'($urandom), idx});
  endtask

  task automatic vec_op(input logic [2:0] op, input logic [1:0] vn, input logic [1:0] vm);
    send_item(op, {32'($urandom), vm, vn, 4'($urandom)});
  endtask

  task automatic load_banks();
    for (int i = 0; i < 16; i++) begin
      write_reg(vdmt_pkg::FUNC_WR_FRONT, 4'(i), pick_float());
      write_reg(vdmt_pkg::FUNC_WR_BACK, 4'(i), pick_float());
    end
  endtask

  task automatic wait_results();
    while (pending != 0) @(negedge clk);
  endtask

  // idle unit, then a flush mode write
  task automatic set_flush(input logic mode);
    s_axis_tvalid <= 1'b0;
    wait_results();
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= mode;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  task automatic random_items(input int count);
    int k;
    logic [39:0] d;
    for (int n = 0; n < count; n++) begin
      k = $urandom_range(99);
      d = {$urandom, 8'($urandom)};
      d[39:8] = pick_float();
      if (k < 25) send_item(vdmt_pkg::FUNC_WR_FRONT, d);
      else if (k < 40) send_item(vdmt_pkg::FUNC_WR_BACK, d);
      else if (k < 55) send_item(vdmt_pkg::FUNC_RD_FRONT, d);
      else if (k < 70) send_item(vdmt_pkg::FUNC_DOT, d);
      else if (k < 85) send_item(vdmt_pkg::FUNC_XFORM, d);
      else if (k < 93) send_item(vdmt_pkg::FUNC_SWAP, d);
      else if (k < 96) send_item(FUNC_SPARE_LO, d);
      else send_item(FUNC_SPARE_HI, d);
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    load_banks();

    // directed: overflow, tiny sum, invalid product, reads, swaps, spare codes
    for (int i = 0; i < 4; i++) begin
      write_reg(vdmt_pkg::FUNC_WR_FRONT, 4'(i), (i < 2) ? 32'h7F7F_FFFF : 32'h0);
      write_reg(vdmt_pkg::FUNC_WR_FRONT, 4'(4 + i), (i < 2) ? 32'hFF7F_FFFF : 32'h8000_0000);
    end
    vec_op(vdmt_pkg::FUNC_DOT, 2'd1, 2'd0);
    write_reg(vdmt_pkg::FUNC_WR_FRONT, 4'd8, 32'h0000_0001);
    write_reg(vdmt_pkg::FUNC_WR_FRONT, 4'd12, 32'h3F80_0000);
    vec_op(vdmt_pkg::FUNC_DOT, 2'd3, 2'd2);
    write_reg(vdmt_pkg::FUNC_WR_FRONT, 4'd9, 32'h7F80_0000);
    write_reg(vdmt_pkg::FUNC_WR_FRONT, 4'd13, 32'h0);
    vec_op(vdmt_pkg::FUNC_DOT, 2'd3, 2'd2);
    write_reg(vdmt_pkg::FUNC_RD_FRONT, 4'd15, 32'hFFFF_FFFF);
    write_reg(vdmt_pkg::FUNC_RD_FRONT, 4'd0, 32'h0);
    send_item(vdmt_pkg::FUNC_SWAP, '0);
    write_reg(vdmt_pkg::FUNC_RD_FRONT, 4'd5, 32'h0);
    send_item(vdmt_pkg::FUNC_SWAP, '1);
    vec_op(vdmt_pkg::FUNC_XFORM, 2'd0, 2'd3);
    vec_op(vdmt_pkg::FUNC_XFORM, 2'd3, 2'd0);
    send_item(FUNC_SPARE_LO, '1);
    send_item(FUNC_SPARE_HI, '0);
    write_reg(vdmt_pkg::FUNC_WR_BACK, 4'd15, 32'hFFFF_FFFF);

    // sender 37, receiver 53, flush off
    set_flush(1'b0);
    random_items(75);

    // swapped idling, flush on, one full drain midway
    set_flush(1'b1);
    send_idle_pct = 53;
    recv_idle_pct = 37;
    random_items(37);
    s_axis_tvalid <= 1'b0;
    wait_results();
    random_items(36);

    // no idling, flush off, long receiver hold-off
    set_flush(1'b0);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_go <= 1'b1;
    random_items(75);
    s_axis_tvalid <= 1'b0;

    wait_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
